>>> design/xoshiro256ss_generator_top_assert.svh
`ifndef XOSHIRO256SS_GENERATOR_TOP_ASSERT_SVH
`define XOSHIRO256SS_GENERATOR_TOP_ASSERT_SVH

// check cons in the cycle after ante
`define XS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xs256: lbl failed");

// check that cons holds on a later cycle than ante
`define XS_ASSERT_AFTER3(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error("xs256: lbl failed");

`endif

>>> design/xs256_pkg.sv
package xs256_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_SEED = 4'd1;
  localparam pc_t PC_WARM = 4'd10;
  localparam pc_t PC_DRAW = 4'd12;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_GAMMA,
    OP_MUL_LL,
    OP_MUL_HL,
    OP_MUL_LH,
    OP_XS27,
    OP_STORE,
    OP_DRAW_A,
    OP_DRAW_B,
    OP_WARM,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_IDX,
    COND_WARM
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  ksel;
    cond_t cond;
    pc_t   target;
  } uc_word_t;

  function automatic uc_word_t uc(input op_t op, input logic ksel, input cond_t cond,
                                  input pc_t target);
    uc_word_t w;
    w.op     = op;
    w.ksel   = ksel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic uc_word_t uc_rom(input pc_t pc);
    uc_word_t w;
    case (pc)
      4'd0:    w = uc(OP_IDLE,   1'b0, COND_NONE,   PC_IDLE);
      4'd1:    w = uc(OP_GAMMA,  1'b0, COND_NONE,   PC_IDLE);
      4'd2:    w = uc(OP_MUL_LL, 1'b0, COND_NONE,   PC_IDLE);
      4'd3:    w = uc(OP_MUL_HL, 1'b0, COND_NONE,   PC_IDLE);
      4'd4:    w = uc(OP_MUL_LH, 1'b0, COND_NONE,   PC_IDLE);
      4'd5:    w = uc(OP_XS27,   1'b0, COND_NONE,   PC_IDLE);
      4'd6:    w = uc(OP_MUL_LL, 1'b1, COND_NONE,   PC_IDLE);
      4'd7:    w = uc(OP_MUL_HL, 1'b1, COND_NONE,   PC_IDLE);
      4'd8:    w = uc(OP_MUL_LH, 1'b1, COND_NONE,   PC_IDLE);
      4'd9:    w = uc(OP_STORE,  1'b0, COND_IDX,    PC_SEED);
      4'd10:   w = uc(OP_WARM,   1'b0, COND_WARM,   PC_WARM);
      4'd11:   w = uc(OP_NOP,    1'b0, COND_ALWAYS, PC_IDLE);
      4'd12:   w = uc(OP_DRAW_A, 1'b0, COND_NONE,   PC_IDLE);
      4'd13:   w = uc(OP_DRAW_B, 1'b0, COND_ALWAYS, PC_IDLE);
      default: w = uc(OP_NOP,    1'b0, COND_ALWAYS, PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [63:0] rotl45(input logic [63:0] v);
    return (v << 45) | (v >> 19);
  endfunction

  function automatic logic [63:0] rotl7(input logic [63:0] v);
    return (v << 7) | (v >> 57);
  endfunction

endpackage

>>> design/xoshiro256ss_generator_top.sv
// channel | ports                          | accepted when
// in      | in_valid in_command in_seed    | in_valid && !in_stall
// out     | out_valid out_random_word      | out_valid && !out_stall
// A draw steps through dispatch, output scramble with state advance, and output multiply.
// A reseed runs four splitmix64 words through one shared 32x32 multiplier
// (nine microcode steps per word) and 16 warm-up steps.
// Reset clears the state words to zero; draws before the first reseed return zero.
// in_stall is high whenever the sequencer is not at its dispatch step.
// A draw waits at its last step while the output register holds an untaken word.
module xoshiro256ss_generator_top
  import xs256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_random_word
);

  pc_t         pc_r, pc_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [3:0]  warm_r, warm_nxt;
  logic [63:0] s_r [4];
  logic [63:0] s_nxt [4];
  logic [63:0] ctr_r, ctr_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic [63:0] out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  uc_word_t    uw;
  logic [63:0] k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] ctr_add;
  logic [63:0] adv [4];
  logic        hold;

  assign uw = uc_rom(pc_r);
  assign k  = uw.ksel ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    mul_a = z_r[31:0];
    mul_b = k[31:0];
    case (uw.op)
      OP_MUL_HL: mul_a = z_r[63:32];
      OP_MUL_LH: mul_b = k[63:32];
      default: ;
    endcase
  end

  assign prod    = {32'b0, mul_a} * {32'b0, mul_b};
  assign ctr_add = ctr_r + GOLDEN_GAMMA;

  always_comb begin
    adv[2] = s_r[2] ^ s_r[0];
    adv[3] = s_r[3] ^ s_r[1];
    adv[1] = s_r[1] ^ adv[2];
    adv[0] = s_r[0] ^ adv[3];
    adv[2] = adv[2] ^ (s_r[1] << 17);
    adv[3] = rotl45(adv[3]);
  end

  assign hold = (uw.op == OP_DRAW_B) && out_valid_r && out_stall;

  always_comb begin
    pc_nxt        = pc_r + 1'b1;
    idx_nxt       = idx_r;
    warm_nxt      = warm_r;
    s_nxt         = s_r;
    ctr_nxt       = ctr_r;
    z_nxt         = z_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (uw.cond)
      COND_ALWAYS: pc_nxt = uw.target;
      COND_IDX:    if (idx_r != '1) pc_nxt = uw.target;
      COND_WARM:   if (warm_r != '1) pc_nxt = uw.target;
      default: ;
    endcase

    case (uw.op)
      OP_IDLE: begin
        pc_nxt = PC_IDLE;
        if (in_valid) begin
          if (in_command == CMD_DRAW) begin
            pc_nxt = PC_DRAW;
          end else begin
            pc_nxt  = PC_SEED;
            ctr_nxt = in_seed;
          end
        end
      end
      OP_GAMMA: begin
        ctr_nxt = ctr_add;
        z_nxt   = ctr_add ^ (ctr_add >> 30);
      end
      OP_MUL_LL: acc_nxt = prod;
      OP_MUL_HL, OP_MUL_LH: acc_nxt = acc_r + {prod[31:0], 32'b0};
      OP_XS27: z_nxt = acc_r ^ (acc_r >> 27);
      OP_STORE: begin
        s_nxt[idx_r] = acc_r ^ (acc_r >> 31);
        idx_nxt      = idx_r + 1'b1;
      end
      OP_DRAW_A: begin
        tmp_nxt = rotl7(s_r[1] + (s_r[1] << 2));
        s_nxt   = adv;
      end
      OP_DRAW_B: begin
        if (hold) begin
          pc_nxt = pc_r;
        end else begin
          out_nxt       = tmp_r + (tmp_r << 3);
          out_valid_nxt = 1'b1;
        end
      end
      OP_WARM: begin
        s_nxt    = adv;
        warm_nxt = warm_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      idx_r       <= '0;
      warm_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) s_r[i] <= '0;
    end else begin
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      warm_r      <= warm_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
    end
    ctr_r <= ctr_nxt;
    z_r   <= z_nxt;
    acc_r <= acc_nxt;
    tmp_r <= tmp_nxt;
    out_r <= out_nxt;
  end

  assign in_stall        = (uw.op != OP_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_r;

endmodule

>>> design/xs256_checker.sv
`include "xoshiro256ss_generator_top_assert.svh"

module xs256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_command,
  input logic [63:0] in_seed,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_random_word
);

  logic in_fire;
  logic seed_fire;
  logic draw_fire;

  assign in_fire   = in_valid && !in_stall;
  assign seed_fire = in_fire && !in_command && (in_seed == in_seed);
  assign draw_fire = in_fire && in_command;

  `XS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_random_word))
  `XS_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall)
  `XS_ASSERT_NEXT(a_seed_no_word, seed_fire && !out_valid, !out_valid)
  `XS_ASSERT_AFTER3(a_draw_word, draw_fire && !out_valid, out_valid)

endmodule

bind xoshiro256ss_generator_top xs256_checker u_xs256_checker (.*);
